// ----- design/nvw_pkg.sv -----
`default_nettype none

package nvw_pkg;

   // Field widths
   localparam int SITE_W     = 11;
   localparam int NOISE_W    = 17;
   localparam int STEP_W     = 40;
   localparam int SAMPLE_W   = 32;
   localparam int FRAC_W     = 16;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 40;

   localparam logic [CSR_IDX_W-1:0] CSR_LATTICE_SIZE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NOISE_LEVEL  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_SITE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_SITE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_STEPS    = 3'd4;

   // Register reset values
   localparam logic [SITE_W-1:0]  LATTICE_RESET = 11'd64;
   localparam logic [NOISE_W-1:0] NOISE_RESET   = 17'd0;
   localparam logic [SITE_W-1:0]  START_RESET   = 11'd32;
   localparam logic [SITE_W-1:0]  TARGET_RESET  = 11'd0;
   localparam logic [STEP_W-1:0]  MAX_RESET     = 40'd1073741824;

   // Noise of one in Q1.16
   localparam logic [NOISE_W-1:0] ONE_Q16 = 17'h10000;

   // Lattice bound default
   localparam int MAX_SITES_DEFAULT = 1024;

   // Walk state store: one row holds the live walker
   localparam int STATE_ROWS = 2;
   localparam logic [$clog2(STATE_ROWS)-1:0] STATE_ROW = '0;

   typedef struct packed {
      logic [SITE_W-1:0] site;
      logic [STEP_W-1:0] steps;
   } walk_state_type;

endpackage

`default_nettype wire

// ----- design/nvw_channels.sv -----
`default_nettype none

// Random sample channel
interface nvw_req_if import nvw_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] random_sample;

   modport source (output valid, output random_sample, input ready);
   modport sink   (input valid, input random_sample, output ready);
endinterface

// Step result channel
interface nvw_rsp_if import nvw_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [SITE_W-1:0] site_index;
   logic [STEP_W-1:0] step_count;
   logic              run_done;
   logic              timed_out;

   modport source (output valid, output site_index, output step_count,
                   output run_done, output timed_out, input ready);
   modport sink   (input valid, input site_index, input step_count,
                   input run_done, input timed_out, output ready);
endinterface

`default_nettype wire

// ----- design/nvw_ram.sv -----
`default_nettype none

module nvw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- design/noisy_voter_walk_first_passage.sv -----
`default_nettype none

// First-passage walker of the noisy voter model.
// req_chan carries one Q0.32 random sample per transfer; each sample moves the
// walker one step (left, right or stay) and yields exactly one transfer on
// rsp_chan with the new site, the step count of the run and the end flags.
// A run ends on the target site or when the count reaches max_steps; the
// next sample then starts a new run at start_site.
// Each sample passes the load, multiply, sum and done states in order, and
// its result is registered from done. Each step reads the walker state
// from the state RAM, runs two multiply stages and an add stage, then
// compares and writes the state back; the next sample is taken only after
// the write-back.
// Users must write registers through csr_* only while the block is idle;
// the block does not enforce this. Reset (synchronous) loads the register
// defaults and marks a pending restart, so the state RAM needs no clearing.
// When the receiver stalls, the finished result waits in the output
// register and the block holds in its last stage until that register frees.
module noisy_voter_walk_first_passage import nvw_pkg::*; #(
   parameter int MAX_SITES = MAX_SITES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   nvw_req_if.sink               req_chan,
   nvw_rsp_if.source             rsp_chan,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam int LIM_W  = 17;
   localparam int PROD_W = 2 * SITE_W;
   localparam int EN_W   = NOISE_W + SITE_W;
   localparam int MUL_W  = NOISE_W + PROD_W;
   localparam int LHS_W  = SAMPLE_W + PROD_W;
   localparam int SUM_W  = MUL_W + 2;
   localparam int CMP_W  = SUM_W + FRAC_W;

   localparam logic [LIM_W-1:0] MaxSitesLim = LIM_W'(MAX_SITES);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_LOAD = 5'b00010,
      ST_MUL  = 5'b00100,
      ST_SUM  = 5'b01000,
      ST_DONE = 5'b10000
   } fsm_state_type;

   fsm_state_type state_ff, state_in;

   logic [SITE_W-1:0]   lattice_ff;
   logic [NOISE_W-1:0]  noise_ff;
   logic [SITE_W-1:0]   start_ff;
   logic [SITE_W-1:0]   target_ff;
   logic [STEP_W-1:0]   max_ff;

   logic                restart_ff;
   logic [SAMPLE_W-1:0] sample_ff;
   logic [SITE_W-1:0]   site_ff, site_in;
   logic [SITE_W-1:0]   rest_ff, rest_in;
   logic [STEP_W-1:0]   steps_ff, steps_in;
   logic [PROD_W-1:0]   prod_ir_ff, nn_ff;
   logic [EN_W-1:0]     en_ff;
   logic [MUL_W-1:0]    shared_ff, el_ff, er_ff;
   logic [LHS_W-1:0]    lhs_ff;
   logic [SUM_W-1:0]    lnum_ff, tot_ff;

   logic                rsp_valid_ff;
   logic [SITE_W-1:0]   rsp_site_ff;
   logic [STEP_W-1:0]   rsp_steps_ff;
   logic                rsp_done_ff;
   logic                rsp_timeout_ff;

   logic                req_xfer;
   logic                out_load;
   logic [SITE_W-1:0]   lat_lo;
   logic [SITE_W-1:0]   n_eff;
   logic [NOISE_W-1:0]  e_eff;
   logic [NOISE_W-1:0]  one_minus_e;
   logic [SITE_W-1:0]   start_cl;
   walk_state_type      st_rd, st_wr;
   logic [STEP_W-1:0]   steps_prev;
   logic [CMP_W-1:0]    lhs_ext;
   logic                go_left, go_right;
   logic [SITE_W-1:0]   new_site;
   logic                at_target, timeout;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         lattice_ff <= LATTICE_RESET;
         noise_ff   <= NOISE_RESET;
         start_ff   <= START_RESET;
         target_ff  <= TARGET_RESET;
         max_ff     <= MAX_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_LATTICE_SIZE: lattice_ff <= csr_write_data[SITE_W-1:0];
            CSR_NOISE_LEVEL:  noise_ff   <= csr_write_data[NOISE_W-1:0];
            CSR_START_SITE:   start_ff   <= csr_write_data[SITE_W-1:0];
            CSR_TARGET_SITE:  target_ff  <= csr_write_data[SITE_W-1:0];
            CSR_MAX_STEPS:    max_ff     <= csr_write_data[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective lattice size and noise
   assign lat_lo = (lattice_ff < SITE_W'(2)) ? SITE_W'(2) : lattice_ff;
   assign n_eff  = (LIM_W'(lat_lo) > MaxSitesLim) ? MaxSitesLim[SITE_W-1:0] : lat_lo;
   assign e_eff  = (noise_ff > ONE_Q16) ? ONE_Q16 : noise_ff;
   assign one_minus_e = ONE_Q16 - e_eff;

   // Handshakes
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_xfer = req_chan.valid && req_chan.ready;
   assign out_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_chan.ready);

   // Walker state store
   nvw_ram #(
      .WIDTH ($bits(walk_state_type)),
      .DEPTH (STATE_ROWS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (out_load),
      .wr_addr (STATE_ROW),
      .wr_data (st_wr),
      .rd_en   (req_xfer),
      .rd_addr (STATE_ROW),
      .rd_data (st_rd)
   );

   // Sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_xfer) state_in = ST_LOAD;
         ST_LOAD: state_in = ST_MUL;
         ST_MUL:  state_in = ST_SUM;
         ST_SUM:  state_in = ST_DONE;
         ST_DONE: if (out_load) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Restart flag: set when a run ends, consumed when the next step loads
   always_ff @(posedge clock) begin
      if (reset) begin
         restart_ff <= 1'b1;
      end else if (state_ff == ST_LOAD) begin
         restart_ff <= 1'b0;
      end else if (out_load && (at_target || timeout)) begin
         restart_ff <= 1'b1;
      end
   end

   // Load stage: pick the current site and count, clamped into the lattice
   assign start_cl   = (start_ff > n_eff) ? n_eff : start_ff;
   assign site_in    = restart_ff ? start_cl : ((st_rd.site > n_eff) ? n_eff : st_rd.site);
   assign rest_in    = n_eff - site_in;
   assign steps_prev = restart_ff ? '0 : st_rd.steps;
   assign steps_in   = (&steps_prev) ? steps_prev : steps_prev + STEP_W'(1);

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         sample_ff <= req_chan.random_sample;
      end
      if (state_ff == ST_LOAD) begin
         site_ff    <= site_in;
         rest_ff    <= rest_in;
         steps_ff   <= steps_in;
         prod_ir_ff <= PROD_W'(site_in) * PROD_W'(rest_in);
         nn_ff      <= PROD_W'(n_eff) * PROD_W'(n_eff);
         en_ff      <= EN_W'(e_eff) * EN_W'(n_eff);
      end
   end

   // Multiply stage: the terms of both probabilities and the scaled sample
   always_ff @(posedge clock) begin
      if (state_ff == ST_MUL) begin
         shared_ff <= MUL_W'(one_minus_e) * MUL_W'(prod_ir_ff);
         el_ff     <= MUL_W'(en_ff) * MUL_W'(site_ff);
         er_ff     <= MUL_W'(en_ff) * MUL_W'(rest_ff);
         lhs_ff    <= LHS_W'(sample_ff) * LHS_W'(nn_ff);
      end
   end

   // Sum stage: left numerator and left-plus-right numerator
   always_ff @(posedge clock) begin
      if (state_ff == ST_SUM) begin
         lnum_ff <= SUM_W'(el_ff) + SUM_W'(shared_ff);
         tot_ff  <= SUM_W'(el_ff) + SUM_W'(er_ff) + SUM_W'({shared_ff, 1'b0});
      end
   end

   // Decision stage: exact threshold compare and blocked move
   assign lhs_ext  = CMP_W'(lhs_ff);
   assign go_left  = lhs_ext <= {lnum_ff, {FRAC_W{1'b0}}};
   assign go_right = lhs_ext <= {tot_ff, {FRAC_W{1'b0}}};

   always_comb begin
      new_site = site_ff;
      if (go_left) begin
         if (site_ff != '0) new_site = site_ff - SITE_W'(1);
      end else if (go_right) begin
         if (site_ff < n_eff) new_site = site_ff + SITE_W'(1);
      end
   end

   assign at_target   = (new_site == target_ff);
   assign timeout     = !at_target && (steps_ff >= max_ff);
   assign st_wr.site  = new_site;
   assign st_wr.steps = steps_ff;

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_site_ff    <= new_site;
         rsp_steps_ff   <= steps_ff;
         rsp_done_ff    <= at_target || timeout;
         rsp_timeout_ff <= timeout;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.site_index = rsp_site_ff;
   assign rsp_chan.step_count = rsp_steps_ff;
   assign rsp_chan.run_done   = rsp_done_ff;
   assign rsp_chan.timed_out  = rsp_timeout_ff;

   // Checks
   a_site_in_lattice: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MUL |-> site_ff <= n_eff)
      else $error("walker site outside lattice after load");

   a_total_covers_left: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |-> tot_ff >= lnum_ff)
      else $error("left-plus-right numerator below left numerator");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result appeared outside the decision stage");

   a_timeout_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_timeout_ff |-> rsp_done_ff)
      else $error("timeout flagged without run end");

   a_sample_starts_load: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> state_ff == ST_LOAD)
      else $error("sample transfer did not start a state read");

endmodule

`default_nettype wire
